// ===== hw/rtl/hsv_pkg.sv =====
// Shared types, constants and helpers for the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

    // Field widths
    localparam int HUE_W  = 13;
    localparam int FRAC_W = 9;
    localparam int CH_W   = 8;

    // Hue geometry: 1/16 degree steps, 60 degree sectors
    localparam logic [HUE_W-1:0] SECTOR_UNITS = 13'd960;
    localparam logic [HUE_W-1:0] CIRCLE_UNITS = 13'd5760;
    localparam int               DIST_W       = 10;   // holds 0..960

    // Q1.8 fractions, 256 means 1.0
    localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

    // Chroma and numerator widths
    localparam int C_W   = 17;                          // 0..65536
    localparam int NUM_W = 26;                          // 0..65536*960

    // Channel scaling: n*255/(65536*960) == (n*17) >> 22
    localparam int                SCALE_W     = 31;
    localparam logic [4:0]        SCALE_MUL   = 5'd17;
    localparam int                SCALE_SHIFT = 22;
    localparam logic [CH_W-1:0]   CHANNEL_MAX = 8'd255;

    // Pipeline depth
    localparam int NUM_STAGES = 5;

    // 60 degree sectors, named by the colors at their ends
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // Per-stage control from the valid chain
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

    // Front end result: chroma, value, sector, weight of the secondary term
    typedef struct packed {
        logic [C_W-1:0]    c;
        logic [FRAC_W-1:0] val;
        t_sector           sector;
        logic [DIST_W-1:0] f;
    } t_front;

    // Channel numerators over the common denominator 65536*960
    typedef struct packed {
        logic [NUM_W-1:0] num_r;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_b;
    } t_mix;

    // First hue unit of a sector
    function automatic logic [HUE_W-1:0] sector_base(input t_sector sec);
        logic [HUE_W-1:0] base;
        unique case (sec)
            SEC_RY:  base = 13'd0;
            SEC_YG:  base = 13'd960;
            SEC_GC:  base = 13'd1920;
            SEC_CB:  base = 13'd2880;
            SEC_BM:  base = 13'd3840;
            SEC_MR:  base = 13'd4800;
            default: base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hsv_ctl.sv =====
// Valid chain and per-stage load enables of the converter pipeline.
`default_nettype none

module hsv_ctl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output hsv_pkg::t_pipe_ctl      o_ctl
);

    localparam int N = hsv_pkg::NUM_STAGES;

    logic [N-1:0] r_valid;
    logic [N-1:0] n_valid;
    logic [N-1:0] load;

    // A stage loads when it is empty or its item moves on
    always_comb begin
        load[N-1] = !r_valid[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            load[k] = !r_valid[k] || load[k+1];
        end
    end

    always_comb begin
        n_valid[0] = load[0] ? i_valid : r_valid[0];
        for (int k = 1; k < N; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall     = !load[0];
    assign o_valid     = r_valid[N-1];
    assign o_ctl.load  = load;
    assign o_ctl.valid = r_valid;

    // A held item is never overwritten
    genvar g;
    for (g = 0; g < N - 1; g++) begin : g_chk
        a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (load[g] && r_valid[g]) |-> load[g+1])
            else $error("stage %0d loaded over a held item", g);
    end

    // Full pipe under stall pushes back on the sender
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_valid) == N && i_stall) |-> o_stall)
        else $error("full pipeline did not stall the input");

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_front.sv =====
// Stages 1-2: input limiting and hue wrap, then chroma, sector and secondary weight.
`default_nettype none

module hsv_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hsv_pkg::t_pipe_ctl            i_ctl,
    input  wire logic [hsv_pkg::HUE_W-1:0]     i_hue,
    input  wire logic [hsv_pkg::FRAC_W-1:0]    i_saturation,
    input  wire logic [hsv_pkg::FRAC_W-1:0]    i_brightness,
    output hsv_pkg::t_front                    o_front
);

    // Stage 1 registers
    logic [hsv_pkg::HUE_W-1:0]  r_hue1;
    logic [hsv_pkg::FRAC_W-1:0] r_sat1;
    logic [hsv_pkg::FRAC_W-1:0] r_val1;

    logic [hsv_pkg::HUE_W-1:0]  n_hue1;
    logic [hsv_pkg::FRAC_W-1:0] n_sat1;
    logic [hsv_pkg::FRAC_W-1:0] n_val1;

    // Stage 2 registers
    hsv_pkg::t_front            r_front2;
    hsv_pkg::t_front            n_front2;

    logic [hsv_pkg::HUE_W-1:0]  off;
    logic [2*hsv_pkg::FRAC_W-1:0] prod;

    // Wrap hue past full circle once, clamp fractions to 1.0
    always_comb begin
        n_hue1 = (i_hue >= hsv_pkg::CIRCLE_UNITS) ? i_hue - hsv_pkg::CIRCLE_UNITS : i_hue;
        n_sat1 = (i_saturation > hsv_pkg::FRAC_ONE) ? hsv_pkg::FRAC_ONE : i_saturation;
        n_val1 = (i_brightness > hsv_pkg::FRAC_ONE) ? hsv_pkg::FRAC_ONE : i_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_hue1 <= n_hue1;
            r_sat1 <= n_sat1;
            r_val1 <= n_val1;
        end
    end

    // Chroma, sector and weight of the secondary term
    always_comb begin
        prod       = r_val1 * r_sat1;
        n_front2.c = prod[hsv_pkg::C_W-1:0];
        n_front2.val = r_val1;
        priority if (r_hue1 >= 13'd4800) begin
            n_front2.sector = hsv_pkg::SEC_MR;
        end else if (r_hue1 >= 13'd3840) begin
            n_front2.sector = hsv_pkg::SEC_BM;
        end else if (r_hue1 >= 13'd2880) begin
            n_front2.sector = hsv_pkg::SEC_CB;
        end else if (r_hue1 >= 13'd1920) begin
            n_front2.sector = hsv_pkg::SEC_GC;
        end else if (r_hue1 >= hsv_pkg::SECTOR_UNITS) begin
            n_front2.sector = hsv_pkg::SEC_YG;
        end else begin
            n_front2.sector = hsv_pkg::SEC_RY;
        end
        off = r_hue1 - hsv_pkg::sector_base(n_front2.sector);
        // rising secondary in even sectors, falling in odd ones
        if (n_front2.sector[0]) begin
            n_front2.f = hsv_pkg::DIST_W'(hsv_pkg::SECTOR_UNITS - off);
        end else begin
            n_front2.f = off[hsv_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_front2 <= n_front2;
        end
    end

    assign o_front = r_front2;

    // Weight stays within one sector, chroma within value
    a_f_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid[1] |-> (r_front2.f <= hsv_pkg::DIST_W'(hsv_pkg::SECTOR_UNITS)))
        else $error("secondary weight out of range");

    a_c_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid[1] |-> (r_front2.c <= {r_front2.val, 8'd0}))
        else $error("chroma above value");

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_mix.sv =====
// Stages 3-4: component numerators and channel arrangement by sector.
`default_nettype none

module hsv_mix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsv_pkg::t_pipe_ctl i_ctl,
    input  wire hsv_pkg::t_front    i_front,
    output hsv_pkg::t_mix           o_mix
);

    localparam int W = hsv_pkg::NUM_W;

    // Stage 3 registers
    logic [W-1:0]        r_x3;
    logic [W-1:0]        r_m3;
    logic [W-1:0]        r_v3;
    hsv_pkg::t_sector    r_sector3;

    logic [hsv_pkg::C_W-1:0]                a;
    logic [hsv_pkg::C_W+hsv_pkg::DIST_W-1:0] x_prod;
    logic [hsv_pkg::C_W+hsv_pkg::DIST_W-1:0] m_prod;
    logic [hsv_pkg::FRAC_W+hsv_pkg::DIST_W-1:0] v_prod;

    // Stage 4 registers
    hsv_pkg::t_mix       r_mix4;
    hsv_pkg::t_mix       n_mix4;
    logic [W:0]          xm_sum;
    logic [W-1:0]        xm;

    // Offset V-C, then C*f, offset and full value scaled by 960
    always_comb begin
        a      = {i_front.val, 8'd0} - i_front.c;
        x_prod = i_front.c * i_front.f;
        m_prod = a * hsv_pkg::SECTOR_UNITS[hsv_pkg::DIST_W-1:0];
        v_prod = i_front.val * hsv_pkg::SECTOR_UNITS[hsv_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_x3      <= x_prod[W-1:0];
            r_m3      <= m_prod[W-1:0];
            r_v3      <= {v_prod[W-9:0], 8'd0};
            r_sector3 <= i_front.sector;
        end
    end

    // Primary channel gets V, secondary X+M, the third M alone
    always_comb begin
        xm_sum = {1'b0, r_x3} + {1'b0, r_m3};
        xm     = xm_sum[W-1:0];
        unique case (r_sector3)
            hsv_pkg::SEC_RY: begin
                n_mix4.num_r = r_v3; n_mix4.num_g = xm;   n_mix4.num_b = r_m3;
            end
            hsv_pkg::SEC_YG: begin
                n_mix4.num_r = xm;   n_mix4.num_g = r_v3; n_mix4.num_b = r_m3;
            end
            hsv_pkg::SEC_GC: begin
                n_mix4.num_r = r_m3; n_mix4.num_g = r_v3; n_mix4.num_b = xm;
            end
            hsv_pkg::SEC_CB: begin
                n_mix4.num_r = r_m3; n_mix4.num_g = xm;   n_mix4.num_b = r_v3;
            end
            hsv_pkg::SEC_BM: begin
                n_mix4.num_r = xm;   n_mix4.num_g = r_m3; n_mix4.num_b = r_v3;
            end
            default: begin
                n_mix4.num_r = r_v3; n_mix4.num_g = r_m3; n_mix4.num_b = xm;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_mix4 <= n_mix4;
        end
    end

    assign o_mix = r_mix4;

    // Secondary plus offset never tops the full value
    a_xm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid[2] |-> ({1'b0, r_x3} + {1'b0, r_m3} <= {1'b0, r_v3}))
        else $error("secondary numerator above value");

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_scale.sv =====
// Stage 5: scale numerators to channel codes with truncation and saturation.
`default_nettype none

module hsv_scale (
    input  wire logic                        i_clk,
    input  wire hsv_pkg::t_pipe_ctl          i_ctl,
    input  wire hsv_pkg::t_mix               i_mix,
    output logic [hsv_pkg::CH_W-1:0]         o_red,
    output logic [hsv_pkg::CH_W-1:0]         o_green,
    output logic [hsv_pkg::CH_W-1:0]         o_blue
);

    localparam int LAST = hsv_pkg::NUM_STAGES - 1;

    logic [hsv_pkg::CH_W-1:0] r_red;
    logic [hsv_pkg::CH_W-1:0] r_green;
    logic [hsv_pkg::CH_W-1:0] r_blue;

    // n*255/(65536*960) reduces to (n*17) >> 22
    function automatic logic [hsv_pkg::CH_W-1:0] to_channel(
        input logic [hsv_pkg::NUM_W-1:0] num
    );
        logic [hsv_pkg::SCALE_W-1:0]                     prod;
        logic [hsv_pkg::SCALE_W-hsv_pkg::SCALE_SHIFT-1:0] q;
        prod = num * hsv_pkg::SCALE_MUL;
        q    = prod[hsv_pkg::SCALE_W-1:hsv_pkg::SCALE_SHIFT];
        if (q > {1'b0, hsv_pkg::CHANNEL_MAX}) begin
            return hsv_pkg::CHANNEL_MAX;
        end
        return q[hsv_pkg::CH_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[LAST]) begin
            r_red   <= to_channel(i_mix.num_r);
            r_green <= to_channel(i_mix.num_g);
            r_blue  <= to_channel(i_mix.num_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// Top level of the pipelined HSV to RGB converter.
//
// Input channel: i_valid / o_stall with i_hue (1/16 degree, wraps past
// 5759), i_saturation and i_brightness (Q1.8, 256 = 1.0, larger values
// clamp to 1.0). Output channel: o_valid / i_stall with o_red, o_green,
// o_blue (8-bit, truncated). An item moves on a clock edge where valid is
// high and stall is low.
// Five register stages: wrap/clamp, chroma and sector, products,
// channel arrangement, final scale. o_valid rises once the accepted
// item has passed all five registers; one item per clock is taken and
// delivered in steady state while the receiver does not stall.
// Each stage has its own valid bit and loads when empty or when its item
// moves on, so bubbles are squeezed out and new items are taken while a
// result waits at the output.
// When the receiver stalls, the output holds its item; stall reaches
// o_stall only once every stage holds an item.
// Synchronous active-low reset empties all stages; o_valid is low after
// reset and data registers are not cleared.
`default_nettype none

module hsv_to_rgb_converter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [hsv_pkg::HUE_W-1:0]     i_hue,
    input  wire logic [hsv_pkg::FRAC_W-1:0]    i_saturation,
    input  wire logic [hsv_pkg::FRAC_W-1:0]    i_brightness,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [hsv_pkg::CH_W-1:0]           o_red,
    output logic [hsv_pkg::CH_W-1:0]           o_green,
    output logic [hsv_pkg::CH_W-1:0]           o_blue
);

    hsv_pkg::t_pipe_ctl ctl;
    hsv_pkg::t_front    front;
    hsv_pkg::t_mix      mix;

    // Valid chain and load enables
    hsv_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_ctl   (ctl)
    );

    // Stages 1-2
    hsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_front      (front)
    );

    // Stages 3-4
    hsv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_front (front),
        .o_mix   (mix)
    );

    // Stage 5
    hsv_scale u_scale (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_mix   (mix),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

`default_nettype wire

// ===== verif/tb_hsv_to_rgb_converter_top.sv =====
// Self-checking testbench for the pipelined HSV to RGB converter.
`default_nettype none

module tb_hsv_to_rgb_converter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 60;
    localparam int MAX_REPORTS      = 10;

    typedef struct {
        logic [hsv_pkg::HUE_W-1:0]  hue;
        logic [hsv_pkg::FRAC_W-1:0] sat;
        logic [hsv_pkg::FRAC_W-1:0] bri;
    } t_hsv_color;

    typedef struct {
        logic [hsv_pkg::CH_W-1:0] red;
        logic [hsv_pkg::CH_W-1:0] green;
        logic [hsv_pkg::CH_W-1:0] blue;
    } t_rgb_color;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [hsv_pkg::HUE_W-1:0]  i_hue = '0;
    logic [hsv_pkg::FRAC_W-1:0] i_saturation = '0;
    logic [hsv_pkg::FRAC_W-1:0] i_brightness = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [hsv_pkg::CH_W-1:0]   o_red;
    logic [hsv_pkg::CH_W-1:0]   o_green;
    logic [hsv_pkg::CH_W-1:0]   o_blue;

    t_hsv_color pending_colors[$];
    t_rgb_color expected_rgb[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  colors_queued = 0;
    int  colors_taken = 0;
    int  rgb_checked = 0;
    int  mismatches = 0;
    int  backpressure_cycles = 0;
    int  hold_req = 0;
    int  hold_done = 0;
    int  hold_left = 0;
    logic in_accepted = 1'b0;

    hsv_to_rgb_converter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #6 i_clk = ~i_clk;

    // Scale a numerator over 65536*960 to a channel value, truncate and clamp
    function automatic logic [hsv_pkg::CH_W-1:0] scale_channel(input longint unsigned num);
        longint unsigned den;
        longint unsigned q;
        den = 64'd65536 * 64'(hsv_pkg::SECTOR_UNITS);
        q = (num * 64'(hsv_pkg::CHANNEL_MAX)) / den;
        if (q > 64'(hsv_pkg::CHANNEL_MAX))
            q = 64'(hsv_pkg::CHANNEL_MAX);
        return q[hsv_pkg::CH_W-1:0];
    endfunction

    // Exact integer HSV to RGB conversion
    function automatic t_rgb_color hsv_to_rgb_expected(input t_hsv_color col);
        longint unsigned  sec_len, h, s, v, c, pos, hue_dist, cn, xn, mn;
        longint unsigned  nr, ng, nb;
        hsv_pkg::t_sector sec;
        t_rgb_color       res;
        sec_len = 64'(hsv_pkg::SECTOR_UNITS);
        h = 64'(col.hue) % 64'(hsv_pkg::CIRCLE_UNITS);
        s = (col.sat > hsv_pkg::FRAC_ONE) ? 64'(hsv_pkg::FRAC_ONE) : 64'(col.sat);
        v = (col.bri > hsv_pkg::FRAC_ONE) ? 64'(hsv_pkg::FRAC_ONE) : 64'(col.bri);
        c = v * s;
        sec = hsv_pkg::t_sector'(3'(h / sec_len));
        pos = h % (2 * sec_len);
        hue_dist = (pos >= sec_len) ? pos - sec_len : sec_len - pos;
        cn = c * sec_len;
        xn = c * (sec_len - hue_dist);
        mn = (v * 64'(hsv_pkg::FRAC_ONE) - c) * sec_len;
        unique case (sec)
            hsv_pkg::SEC_RY: begin nr = cn; ng = xn; nb = 0;  end
            hsv_pkg::SEC_YG: begin nr = xn; ng = cn; nb = 0;  end
            hsv_pkg::SEC_GC: begin nr = 0;  ng = cn; nb = xn; end
            hsv_pkg::SEC_CB: begin nr = 0;  ng = xn; nb = cn; end
            hsv_pkg::SEC_BM: begin nr = xn; ng = 0;  nb = cn; end
            default: begin nr = cn; ng = 0;  nb = xn; end
        endcase
        res.red   = scale_channel(nr + mn);
        res.green = scale_channel(ng + mn);
        res.blue  = scale_channel(nb + mn);
        return res;
    endfunction

    task automatic queue_color(input int h, input int s, input int b);
        t_hsv_color col;
        col.hue = h[hsv_pkg::HUE_W-1:0];
        col.sat = s[hsv_pkg::FRAC_W-1:0];
        col.bri = b[hsv_pkg::FRAC_W-1:0];
        pending_colors.push_back(col);
        colors_queued++;
    endtask

    // Fraction mostly in range, sometimes at the ends or above one
    function automatic int pick_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 256);
        else if (r < 90)
            return $urandom_range(0, 1) ? 256 : 0;
        return $urandom_range(0, 511);
    endfunction

    task automatic queue_random_colors(input int n);
        int h, r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                h = $urandom_range(0, 8191);
            else if (r < 20)
                h = $urandom_range(0, 5) * 960 + $urandom_range(0, 1) - 1;
            else
                h = $urandom_range(0, 5759);
            if (h < 0)
                h = 5759;
            queue_color(h, pick_fraction(), pick_fraction());
        end
    endtask

    task automatic wait_drained();
        while (colors_taken != colors_queued || expected_rgb.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        @(posedge i_clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_colors(n);
        wait_drained();
    endtask

    task automatic report_mismatch(input string what, input t_rgb_color exp_rgb);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, what, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                     o_red, o_green, o_blue);
    endtask

    // Input driver: new item only when the line is empty or the last one was taken
    always @(negedge i_clk) begin : drive_colors
        t_hsv_color nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_accepted) begin
            if (pending_colors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_colors.pop_front();
                i_valid      <= 1'b1;
                i_hue        <= nxt.hue;
                i_saturation <= nxt.sat;
                i_brightness <= nxt.bri;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output stall: long hold on request, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= LONG_HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Record accepted inputs and check delivered results
    always @(posedge i_clk) begin : check_rgb
        t_hsv_color col;
        t_rgb_color exp_rgb;
        in_accepted <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            col.hue = i_hue;
            col.sat = i_saturation;
            col.bri = i_brightness;
            expected_rgb.push_back(hsv_to_rgb_expected(col));
            colors_taken++;
        end
        if (i_rst_n && i_valid && o_stall)
            backpressure_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rgb.size() == 0) begin
                exp_rgb = '{default: '0};
                report_mismatch("unexpected result", exp_rgb);
            end else begin
                exp_rgb = expected_rgb.pop_front();
                rgb_checked++;
                if (o_red !== exp_rgb.red || o_green !== exp_rgb.green ||
                    o_blue !== exp_rgb.blue)
                    report_mismatch("channel mismatch", exp_rgb);
            end
        end
    end

    // Hard limit on run length
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed: primaries, sector edges, wrap, clamps, extremes
        queue_color(0, 256, 256);
        queue_color(960, 256, 256);
        queue_color(1920, 256, 256);
        queue_color(2880, 256, 256);
        queue_color(3840, 256, 256);
        queue_color(4800, 256, 256);
        queue_color(5759, 256, 256);
        queue_color(959, 256, 256);
        queue_color(480, 256, 256);
        queue_color(5760, 256, 256);
        queue_color(6719, 200, 100);
        queue_color(8191, 511, 511);
        queue_color(0, 0, 0);
        queue_color(0, 0, 256);
        queue_color(1000, 256, 0);
        queue_color(2000, 257, 300);
        queue_color(3000, 511, 128);
        queue_color(4000, 128, 511);
        queue_color(1234, 1, 1);
        queue_color(4321, 255, 255);
        queue_color(7000, 170, 85);
        queue_color(2400, 128, 128);
        wait_drained();

        // Random colors under the idling mixes
        run_phase(0, 0, 450);
        run_phase(68, 0, 450);
        run_phase(0, 68, 450);
        run_phase(18, 18, 450);

        // Long output hold with a steady sender, so the pipe fills up
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_colors(100);
        hold_req = hold_req + 1;
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d colors (directed, four idling mixes, long hold); %0d checked",
                 colors_taken, rgb_checked);
        $display("Input stalled by the converter on %0d cycles; %0d mismatches, %0d left over",
                 backpressure_cycles, mismatches, expected_rgb.size());
        if (mismatches == 0 && expected_rgb.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
